// File: rtl/core/uvs_pkg.sv
// uvs_pkg: shared constants and types for the UV sphere vertex generator.
// Holds the sine polynomial coefficients, register indexes and the
// sideband record carried alongside the vertex pipeline. No dependencies.
`default_nettype none

package uvs_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int INDEX_BITS_DEF = 8;

    // Q30 odd polynomial coefficients for sin over a quarter turn
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172273;

    localparam logic [16:0] COORD_MAX = 17'd65535;

    localparam logic [15:0] RADIUS_RST      = 16'd256;
    localparam logic [15:0] SLICE_STEP_RST  = 16'd4096;
    localparam logic [15:0] STACK_STEP_RST  = 16'd2048;

    typedef enum logic [1:0] {
        CFG_RADIUS     = 2'd0,
        CFG_SLICE_STEP = 2'd1,
        CFG_STACK_STEP = 2'd2,
        CFG_NONE       = 2'd3
    } cfg_idx_t;

    typedef enum logic [1:0] {
        REQ_CAPS  = 2'd0,
        REQ_UPPER = 2'd1,
        REQ_LOWER = 2'd2,
        REQ_BAD   = 2'd3
    } req_type_t;

    // travels beside the vertex through every pipeline stage
    typedef struct packed {
        logic       valid;
        logic [2:0] num;
        logic       last;
        logic       pole;
        logic       pole_neg;
    } side_t;

endpackage

`default_nettype wire

// File: rtl/core/uvs_horner_cell.sv
// uvs_horner_cell: one Horner step of the sine polynomial, acc = C - t2*acc.
// Registered; passes t, t2 and quadrant to the next cell. Uses no package.
`default_nettype none

module uvs_horner_cell #(
    parameter logic [30:0] COEF = 31'd0
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [30:0] t_in,
    input  wire logic [30:0] t2_in,
    input  wire logic [30:0] acc_in,
    input  wire logic [1:0]  quad_in,
    output logic      [30:0] t_out,
    output logic      [30:0] t2_out,
    output logic      [30:0] acc_out,
    output logic      [1:0]  quad_out
);

    logic [61:0] prod;
    logic [30:0] acc_next;

    assign prod     = {31'd0, t2_in} * {31'd0, acc_in};
    assign acc_next = COEF - prod[60:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_out    <= t_in;
            t2_out   <= t2_in;
            acc_out  <= acc_next;
            quad_out <= quad_in;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/uvs_sine_pipe.sv
// uvs_sine_pipe: Q1.15 sine of a turn-fraction angle, seven register stages.
// Quadrant fold, square, a chain of four uvs_horner_cell, then round.
// Depends on uvs_pkg and uvs_horner_cell.
`default_nettype none

module uvs_sine_pipe #(
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output logic      [14:0]           mag,
    output logic                       neg
);

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

    logic [30:0] t_raw;
    logic [30:0] t_fold;
    logic [30:0] t0_reg;
    logic [1:0]  q0_reg;
    logic [61:0] sq;
    logic [30:0] t1_reg;
    logic [30:0] t21_reg;
    logic [1:0]  q1_reg;

    logic [30:0] ct  [0:4];
    logic [30:0] ct2 [0:4];
    logic [30:0] cac [0:4];
    logic [1:0]  cq  [0:4];

    logic [61:0] fin;
    logic [32:0] rnd;

    localparam logic [30:0] COEFS [0:3] = '{uvs_pkg::SIN_C7, uvs_pkg::SIN_C5,
                                            uvs_pkg::SIN_C3, uvs_pkg::SIN_C1};

    assign t_raw  = {1'b0, angle[ANGLE_BITS-3:0], {(32-ANGLE_BITS){1'b0}}};
    assign t_fold = angle[ANGLE_BITS-2] ? (ONE_Q30 - t_raw) : t_raw;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg <= t_fold;
            q0_reg <= angle[ANGLE_BITS-1:ANGLE_BITS-2];
        end
    end

    assign sq = {31'd0, t0_reg} * {31'd0, t0_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg  <= t0_reg;
            t21_reg <= sq[60:30];
            q1_reg  <= q0_reg;
        end
    end

    assign ct[0]  = t1_reg;
    assign ct2[0] = t21_reg;
    assign cac[0] = uvs_pkg::SIN_C9;
    assign cq[0]  = q1_reg;

    for (genvar i = 0; i < 4; i++)
    begin : g_cell
        uvs_horner_cell #(
            .COEF (COEFS[i])
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .t_in     (ct[i]),
            .t2_in    (ct2[i]),
            .acc_in   (cac[i]),
            .quad_in  (cq[i]),
            .t_out    (ct[i+1]),
            .t2_out   (ct2[i+1]),
            .acc_out  (cac[i+1]),
            .quad_out (cq[i+1])
        );
    end

    assign fin = {31'd0, ct[4]} * {31'd0, cac[4]};
    assign rnd = {1'b0, fin[61:30]} + 33'h0000_4000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag <= (rnd[32:15] > 18'd32767) ? 15'h7FFF : rnd[29:15];
            neg <= cq[4][1];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/uv_sphere_vertex_generator.sv
// uv_sphere_vertex_generator: top level. Request sequencer, four sine pipes
// and a three-stage coordinate scaler with output register.
// Depends on uvs_pkg and uvs_sine_pipe.
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+------------------------------------------
//  s       | s_tvalid / s_tready   | s_tuser: req_type;
//          |                       | s_tdata: slice_index, stack_index
//  m       | m_tvalid / m_tready   | m_tdata: x,y,z; m_tuser: vertex_number;
//          |                       | m_tlast: last_vertex
//  cfg     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Six output transactions per request, one per cycle while m is not stalled; a new
// request is taken on the cycle the sixth vertex issues.
// Each vertex passes the sine pipes, the scale stages and the output register.
// A stall on m freezes the whole pipeline; bubbles are not squeezed out.
// Reset clears the sequencer, valid line and config registers to defaults.
// Request type 3 is accepted and dropped without results.
`default_nettype none

module uv_sphere_vertex_generator #(
    parameter int ANGLE_BITS = uvs_pkg::ANGLE_BITS_DEF,
    parameter int INDEX_BITS = uvs_pkg::INDEX_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [1:0]  s_tuser,   // [1:0] req_type
    input  wire logic [15:0] s_tdata,   // [7:0] slice, [15:8] stack
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [55:0] m_tdata,   // [16:0] x, [33:17] y, [50:34] z
    output logic      [2:0]  m_tuser,   // [2:0] vertex_number
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);

    localparam int AB = ANGLE_BITS;
    localparam logic [AB-1:0] QUARTER = {2'b01, {(AB-2){1'b0}}};
    localparam logic [7:0] IDX_MASK =
        (INDEX_BITS >= 8) ? 8'hFF : 8'((1 << INDEX_BITS) - 1);
    localparam int SIN_LAT = 7;
    localparam int DEPTH   = SIN_LAT + 3;

    // configuration
    logic [15:0] radius_reg;
    logic [15:0] slice_step_reg;
    logic [15:0] stack_step_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= uvs_pkg::RADIUS_RST;
            slice_step_reg <= uvs_pkg::SLICE_STEP_RST;
            stack_step_reg <= uvs_pkg::STACK_STEP_RST;
        end
        else if (cfg_valid)
        begin
            unique case (uvs_pkg::cfg_idx_t'(cfg_index))
                uvs_pkg::CFG_RADIUS:     radius_reg     <= cfg_data;
                uvs_pkg::CFG_SLICE_STEP: slice_step_reg <= cfg_data;
                uvs_pkg::CFG_STACK_STEP: stack_step_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline advance: whole datapath moves unless the output is held
    logic en;
    assign en = !m_tvalid || m_tready;

    // request decode
    logic [1:0]  in_type;
    logic [7:0]  in_s;
    logic [7:0]  in_k;
    logic [24:0] th0_p, th1_p, p0_p, p1_p, top_p, bot_p;
    logic [AB-1:0] p0_a, p1_a;
    logic [AB-1:0] pa_sel, pb_sel;

    assign in_type = s_tuser;
    assign in_s    = s_tdata[7:0] & IDX_MASK;
    assign in_k    = s_tdata[15:8] & IDX_MASK;

    assign th0_p = 25'(in_s) * 25'(slice_step_reg);
    assign th1_p = (25'(in_s) + 25'd1) * 25'(slice_step_reg);
    assign p0_p  = 25'(in_k) * 25'(stack_step_reg);
    assign p1_p  = (25'(in_k) + 25'd1) * 25'(stack_step_reg);
    assign top_p = 25'(QUARTER) - 25'(stack_step_reg);
    assign bot_p = 25'(stack_step_reg) - 25'(QUARTER);
    assign p0_a  = p0_p[AB-1:0];
    assign p1_a  = p1_p[AB-1:0];

    always_comb
    begin
        unique case (uvs_pkg::req_type_t'(in_type))
            uvs_pkg::REQ_CAPS:
            begin
                pa_sel = top_p[AB-1:0];
                pb_sel = bot_p[AB-1:0];
            end
            uvs_pkg::REQ_LOWER:
            begin
                pa_sel = AB'(0) - p1_a;
                pb_sel = AB'(0) - p0_a;
            end
            default:
            begin
                pa_sel = p0_a;
                pb_sel = p1_a;
            end
        endcase
    end

    // sequencer
    logic          busy_reg;
    logic [2:0]    cnt_reg;
    logic          caps_reg;
    logic [AB-1:0] th0_reg, th1_reg, pa_reg, pb_reg;
    logic          accept;
    logic          issue;
    logic          last_cnt;

    assign last_cnt = (cnt_reg == 3'd5);
    assign s_tready = en && (!busy_reg || last_cnt);
    assign accept   = s_tvalid && s_tready;
    assign issue    = busy_reg && en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 3'd0;
        end
        else if (accept)
        begin
            busy_reg <= (in_type != uvs_pkg::REQ_BAD);
            cnt_reg  <= 3'd0;
        end
        else if (issue)
        begin
            busy_reg <= !last_cnt;
            cnt_reg  <= cnt_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            caps_reg <= (in_type == uvs_pkg::REQ_CAPS);
            th0_reg  <= th0_p[AB-1:0];
            th1_reg  <= th1_p[AB-1:0];
            pa_reg   <= pa_sel;
            pb_reg   <= pb_sel;
        end
    end

    // per-vertex angle selection
    logic [AB-1:0] phi, th;
    uvs_pkg::side_t side_in;

    always_comb
    begin
        phi = pa_reg;
        th  = th0_reg;
        unique case (cnt_reg)
            3'd0: begin phi = pa_reg; th = th0_reg; end
            3'd1: begin phi = pa_reg; th = caps_reg ? th0_reg : th1_reg; end
            3'd2: begin phi = caps_reg ? pa_reg : pb_reg; th = th1_reg; end
            3'd3: begin phi = pb_reg; th = th0_reg; end
            3'd4: begin phi = caps_reg ? pb_reg : pa_reg; th = caps_reg ? th1_reg : th0_reg; end
            3'd5: begin phi = pb_reg; th = caps_reg ? th0_reg : th1_reg; end
            default: ;
        endcase
        side_in.valid    = busy_reg;
        side_in.num      = cnt_reg;
        side_in.last     = last_cnt;
        side_in.pole     = caps_reg && (cnt_reg == 3'd0 || cnt_reg == 3'd3);
        side_in.pole_neg = (cnt_reg == 3'd3);
    end

    // four sine lanes: sin/cos of phi and theta
    logic [14:0] sp_m, cp_m, st_m, ct_m;
    logic        sp_n, cp_n, st_n, ct_n;

    uvs_sine_pipe #(.ANGLE_BITS(AB)) u_sin_phi (
        .clk(clk), .en(en), .angle(phi), .mag(sp_m), .neg(sp_n));
    uvs_sine_pipe #(.ANGLE_BITS(AB)) u_cos_phi (
        .clk(clk), .en(en), .angle(phi + QUARTER), .mag(cp_m), .neg(cp_n));
    uvs_sine_pipe #(.ANGLE_BITS(AB)) u_sin_th (
        .clk(clk), .en(en), .angle(th), .mag(st_m), .neg(st_n));
    uvs_sine_pipe #(.ANGLE_BITS(AB)) u_cos_th (
        .clk(clk), .en(en), .angle(th + QUARTER), .mag(ct_m), .neg(ct_n));

    // sideband line
    uvs_pkg::side_t side_reg [0:DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                side_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            side_reg[0] <= side_in;
            for (int i = 1; i < DEPTH; i++)
            begin
                side_reg[i] <= side_reg[i-1];
            end
        end
    end

    // scale stage 1: r*|cos phi|, r*|sin phi|
    logic [30:0] rc_reg, ry_reg;
    logic [14:0] st1_reg, ct1_reg;
    logic        xn1_reg, zn1_reg, yn1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rc_reg  <= 31'(radius_reg) * 31'(cp_m);
            ry_reg  <= 31'(radius_reg) * 31'(sp_m);
            st1_reg <= st_m;
            ct1_reg <= ct_m;
            xn1_reg <= cp_n ^ st_n;
            zn1_reg <= cp_n ^ ct_n;
            yn1_reg <= sp_n;
        end
    end

    // scale stage 2: times |sin th|, |cos th|; y rounded
    logic [45:0] px_reg, pz_reg;
    logic [16:0] y2_reg;
    logic        xn2_reg, zn2_reg;
    logic [31:0] yr;
    logic [16:0] ymag;

    assign yr   = {1'b0, ry_reg} + 32'h0000_4000;
    assign ymag = (yr[31:15] > uvs_pkg::COORD_MAX) ? uvs_pkg::COORD_MAX : yr[31:15];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg  <= 46'(rc_reg) * 46'(st1_reg);
            pz_reg  <= 46'(rc_reg) * 46'(ct1_reg);
            y2_reg  <= yn1_reg ? (17'd0 - ymag) : ymag;
            xn2_reg <= xn1_reg;
            zn2_reg <= zn1_reg;
        end
    end

    // scale stage 3: round x, z
    logic [16:0] x3_reg, y3_reg, z3_reg;
    logic [46:0] xr, zr;
    logic [16:0] xmag, zmag;

    assign xr   = {1'b0, px_reg} + 47'h0000_2000_0000;
    assign zr   = {1'b0, pz_reg} + 47'h0000_2000_0000;
    assign xmag = (xr[46:30] > uvs_pkg::COORD_MAX) ? uvs_pkg::COORD_MAX : xr[46:30];
    assign zmag = (zr[46:30] > uvs_pkg::COORD_MAX) ? uvs_pkg::COORD_MAX : zr[46:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x3_reg <= xn2_reg ? (17'd0 - xmag) : xmag;
            z3_reg <= zn2_reg ? (17'd0 - zmag) : zmag;
            y3_reg <= y2_reg;
        end
    end

    // output register; poles override the computed point
    uvs_pkg::side_t tail;
    logic [16:0] out_x, out_y, out_z;

    assign tail  = side_reg[DEPTH-1];
    assign out_x = tail.pole ? 17'd0 : x3_reg;
    assign out_z = tail.pole ? 17'd0 : z3_reg;
    assign out_y = tail.pole ? (tail.pole_neg ? (17'd0 - 17'(radius_reg))
                                              : 17'(radius_reg))
                             : y3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= tail.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_tdata <= {5'd0, out_z, out_y, out_x};
            m_tuser <= tail.num;
            m_tlast <= tail.last;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg <= 3'd5)
        else $error("vertex counter out of range");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_type != uvs_pkg::REQ_BAD) |=> (busy_reg && cnt_reg == 3'd0))
        else $error("valid request did not start sequencer");

    a_last_is_five: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == 3'd5)))
        else $error("last flag disagrees with vertex number");

    a_no_accept_midrun: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !last_cnt) |-> !s_tready)
        else $error("request taken during a run");
`endif

endmodule

`default_nettype wire

// File: tb/uv_sphere_vertex_generator_test.sv
// Self-checking testbench for uv_sphere_vertex_generator: directed table then
// random requests, vertices predicted in-bench and compared per field.
// Depends on uvs_pkg and the generator RTL.
`timescale 1ns / 100ps

module uv_sphere_vertex_generator_test;

    localparam int ABITS = 16;
    localparam int LIMIT = 400000;

    typedef struct {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
        logic [2:0]  num;
        logic        last;
    } vertex_t;

    typedef struct {
        uvs_pkg::req_type_t kind;
        logic [7:0]  slice;
        logic [7:0]  stack;
        logic        typed;   // row has expected vertices 0 and 3 typed in
        logic [16:0] top_y;   // expected y of the north pole vertex
    } row_t;

    logic        clk, rst_n;
    logic        s_tvalid, s_tready;
    logic [1:0]  s_tuser;
    logic [15:0] s_tdata;
    logic        m_tvalid, m_tready;
    logic [55:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid, cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    uv_sphere_vertex_generator DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser),
        .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser), .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // shadow copy of the register file
    logic [15:0] radius_q, slice_step_q, stack_step_q;

    vertex_t pending_vertices[$];
    int errors, cycles, vertices_seen, requests_sent;
    int send_idle_pct, recv_idle_pct;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [16:0] got,
                                   input logic [16:0] want);
        $display("mismatch at vertex %0d: %s got %h want %h",
                 vertices_seen, what, got, want);
        errors++;
    endtask

    function automatic void queue_vertex(input vertex_t v);
        pending_vertices.insert(pending_vertices.size(), v);
    endfunction

    // ---------------------------------------------------------------
    // Predictor: Q30 sine polynomial, Q1.15 sin/cos, Q8.8 coordinates
    // ---------------------------------------------------------------
    function automatic longint sine_q15(input longint unsigned ang);
        longint unsigned a, quad, t, t2, acc, m;
        a    = ang & ((64'd1 << ABITS) - 1);
        quad = (a >> (ABITS - 2)) & 3;
        t    = (a & ((64'd1 << (ABITS - 2)) - 1)) << (32 - ABITS);
        if (quad[0])
            t = (64'd1 << 30) - t;
        t2  = (t * t) >> 30;
        acc = 64'd172273;
        acc = 64'd5026995 - ((t2 * acc) >> 30);
        acc = 64'd85569306 - ((t2 * acc) >> 30);
        acc = 64'd693598668 - ((t2 * acc) >> 30);
        acc = 64'd1686629713 - ((t2 * acc) >> 30);
        m = (((t * acc) >> 30) + (64'd1 << 14)) >> 15;
        if (m > 32767)
            m = 32767;
        return (quad >= 2) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic [16:0] clamp_coord(input longint unsigned mag,
                                                input bit neg);
        longint v;
        if (mag > 65535)
            mag = 65535;
        v = neg ? -longint'(mag) : longint'(mag);
        return v[16:0];
    endfunction

    function automatic longint unsigned mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [16:0] scale_pair(input longint a, input longint b);
        longint unsigned mag;
        mag = (longint'(radius_q) * mag_of(a) * mag_of(b) + (64'd1 << 29)) >> 30;
        return clamp_coord(mag, (a < 0) != (b < 0));
    endfunction

    function automatic vertex_t surface_vertex(input int k, input longint unsigned phi,
                                               input longint unsigned th);
        vertex_t v;
        longint cp, sp, st, ct;
        cp = sine_q15(phi + (1 << (ABITS - 2)));
        sp = sine_q15(phi);
        st = sine_q15(th);
        ct = sine_q15(th + (1 << (ABITS - 2)));
        v.x = scale_pair(cp, st);
        v.y = clamp_coord((longint'(radius_q) * mag_of(sp) + (1 << 14)) >> 15, sp < 0);
        v.z = scale_pair(cp, ct);
        v.num = k[2:0];
        v.last = (k == 5);
        return v;
    endfunction

    function automatic vertex_t pole_vertex(input int k, input bit south);
        vertex_t v;
        v.x = '0;
        v.z = '0;
        v.y = clamp_coord(radius_q, south);
        v.num = k[2:0];
        v.last = (k == 5);
        return v;
    endfunction

    // queue the six vertices of one request (none for the reserved type);
    // typed rows take their pole vertices from the table
    task automatic predict_patch(input uvs_pkg::req_type_t kind, input logic [7:0] s,
                                 input logic [7:0] st, input logic typed,
                                 input logic [16:0] top_y);
        longint unsigned am, th0, th1, p0, p1, n0, n1, b, q;
        longint unsigned phi_a[6], th_a[6];
        vertex_t patch[6];
        am  = (64'd1 << ABITS) - 1;
        q   = 64'd1 << (ABITS - 2);
        b   = stack_step_q;
        th0 = (s * longint'(slice_step_q)) & am;
        th1 = ((s + 1) * longint'(slice_step_q)) & am;
        p0  = (st * b) & am;
        p1  = ((st + 1) * b) & am;
        n0  = (am + 1 - p0) & am;
        n1  = (am + 1 - p1) & am;
        case (kind)
            uvs_pkg::REQ_CAPS:
            begin
                patch[0] = pole_vertex(0, 1'b0);
                patch[1] = surface_vertex(1, (q - b) & am, th0);
                patch[2] = surface_vertex(2, (q - b) & am, th1);
                patch[3] = pole_vertex(3, 1'b1);
                patch[4] = surface_vertex(4, (b - q) & am, th1);
                patch[5] = surface_vertex(5, (b - q) & am, th0);
                if (typed)
                begin
                    // poles are fixed: (0, r, 0) and (0, -r, 0)
                    patch[0] = '{x: 17'd0, y: top_y, z: 17'd0, num: 3'd0, last: 1'b0};
                    patch[3] = '{x: 17'd0, y: 17'd0 - top_y, z: 17'd0, num: 3'd3,
                                 last: 1'b0};
                end
                for (int k = 0; k < 6; k++)
                    queue_vertex(patch[k]);
            end
            uvs_pkg::REQ_UPPER, uvs_pkg::REQ_LOWER:
            begin
                if (kind == uvs_pkg::REQ_UPPER)
                begin
                    phi_a = '{p0, p0, p1, p1, p0, p1};
                end
                else
                begin
                    phi_a = '{n1, n1, n0, n0, n1, n0};
                end
                th_a = '{th0, th1, th1, th0, th0, th1};
                for (int k = 0; k < 6; k++)
                    queue_vertex(surface_vertex(k, phi_a[k], th_a[k]));
            end
            default: ;  // reserved type: dropped
        endcase
    endtask

    // ---------------------------------------------------------------
    // Drivers: change on the falling edge, sample on the rising edge
    // ---------------------------------------------------------------
    // valid stays up after the transaction so the next request can follow
    // directly; wait_idle drops it
    task automatic send_request(input uvs_pkg::req_type_t kind, input logic [7:0] s,
                                input logic [7:0] st, input logic typed,
                                input logic [16:0] top_y);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {st, s};
        predict_patch(kind, s, st, typed, top_y);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        requests_sent++;
    endtask

    task automatic write_register(input uvs_pkg::cfg_idx_t idx, input logic [15:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            uvs_pkg::CFG_RADIUS:     radius_q     = value;
            uvs_pkg::CFG_SLICE_STEP: slice_step_q = value;
            uvs_pkg::CFG_STACK_STEP: stack_step_q = value;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, drain, then give a dropped reserved request time to leave
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_vertices.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // receiver: random back-pressure, checks each vertex transaction
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        vertex_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_vertices.size() == 0)
            begin
                report_mismatch("unexpected vertex x", m_tdata[16:0], 17'd0);
            end
            else
            begin
                want = pending_vertices.pop_front();
                if (m_tdata[16:0] !== want.x)  report_mismatch("x", m_tdata[16:0], want.x);
                if (m_tdata[33:17] !== want.y) report_mismatch("y", m_tdata[33:17], want.y);
                if (m_tdata[50:34] !== want.z) report_mismatch("z", m_tdata[50:34], want.z);
                if (m_tuser !== want.num)
                    report_mismatch("num", 17'(m_tuser), 17'(want.num));
                if (m_tlast !== want.last)
                    report_mismatch("last", 17'(m_tlast), 17'(want.last));
            end
            vertices_seen++;
        end
    end

    // directed rows; pole y can be read straight off the radius
    row_t directed_rows[0:11] = '{
        '{uvs_pkg::REQ_CAPS,  8'd0,   8'd0,   1'b1, 17'd256},
        '{uvs_pkg::REQ_CAPS,  8'd255, 8'd255, 1'b1, 17'd256},
        '{uvs_pkg::REQ_UPPER, 8'd0,   8'd0,   1'b0, 17'd0},
        '{uvs_pkg::REQ_UPPER, 8'd255, 8'd255, 1'b0, 17'd0},
        '{uvs_pkg::REQ_UPPER, 8'd15,  8'd7,   1'b0, 17'd0},
        '{uvs_pkg::REQ_LOWER, 8'd0,   8'd0,   1'b0, 17'd0},
        '{uvs_pkg::REQ_LOWER, 8'd255, 8'd255, 1'b0, 17'd0},
        '{uvs_pkg::REQ_LOWER, 8'hAA,  8'h55,  1'b0, 17'd0},
        '{uvs_pkg::REQ_BAD,   8'hFF,  8'hFF,  1'b0, 17'd0},
        '{uvs_pkg::REQ_UPPER, 8'h55,  8'hAA,  1'b0, 17'd0},
        '{uvs_pkg::REQ_BAD,   8'd0,   8'd0,   1'b0, 17'd0},
        '{uvs_pkg::REQ_CAPS,  8'd128, 8'd3,   1'b1, 17'd256}
    };

    task automatic random_burst(input int n);
        uvs_pkg::req_type_t kind;
        for (int i = 0; i < n; i++)
        begin
            // mostly valid patches, an occasional reserved type
            kind = ($urandom_range(19) == 0) ? uvs_pkg::REQ_BAD
                                             : uvs_pkg::req_type_t'($urandom_range(2));
            send_request(kind, 8'($urandom_range(255)), 8'($urandom_range(255)),
                         1'b0, 17'd0);
        end
    endtask

    initial
    begin
        s_tvalid = 1'b0; s_tuser = '0; s_tdata = '0;
        cfg_valid = 1'b0; cfg_index = uvs_pkg::CFG_NONE; cfg_data = '0;
        m_tready = 1'b0;
        rst_n = 1'b0;
        errors = 0; cycles = 0; vertices_seen = 0; requests_sent = 0;
        send_idle_pct = 24; recv_idle_pct = 78;
        radius_q = uvs_pkg::RADIUS_RST; slice_step_q = uvs_pkg::SLICE_STEP_RST;
        stack_step_q = uvs_pkg::STACK_STEP_RST;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part at reset settings
        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].kind, directed_rows[i].slice,
                         directed_rows[i].stack, directed_rows[i].typed,
                         directed_rows[i].top_y);
        end
        wait_idle();

        // extremes of every register, including the maximum radius
        write_register(uvs_pkg::CFG_RADIUS, 16'hFFFF);
        write_register(uvs_pkg::CFG_SLICE_STEP, 16'hFFFF);
        write_register(uvs_pkg::CFG_STACK_STEP, 16'd32768);
        random_burst(30);
        wait_idle();
        write_register(uvs_pkg::CFG_RADIUS, 16'd0);
        write_register(uvs_pkg::CFG_SLICE_STEP, 16'd0);
        write_register(uvs_pkg::CFG_STACK_STEP, 16'd0);
        random_burst(20);
        wait_idle();

        // random settings, three idling profiles
        for (int phase = 0; phase < 6; phase++)
        begin
            send_idle_pct = (phase < 2) ? 24 : (phase < 4) ? 78 : 0;
            recv_idle_pct = (phase < 2) ? 78 : (phase < 4) ? 24 : 0;
            write_register(uvs_pkg::CFG_RADIUS, 16'($urandom_range(65535)));
            write_register(uvs_pkg::CFG_SLICE_STEP, 16'($urandom_range(65535)));
            write_register(uvs_pkg::CFG_STACK_STEP, 16'($urandom_range(32768)));
            random_burst(50);
            wait_idle();
        end

        $display("covered %0d requests, %0d vertices, caps/bands/reserved types",
                 requests_sent, vertices_seen);
        $display("across reset, extreme and random register settings");
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
